[rtl/wcu_pkg.sv]
// Package for the Wolff cluster update block: widths, codes, states, generator step.
`default_nettype none
package wcu_pkg;

  localparam int LATTICE_SIDE_DEFAULT = 64;
  localparam int COORD_IN_W = 6;
  localparam int SIZE_W = 13;
  localparam int THRESH_W = 16;
  localparam int RNG_W = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int KIND_W = 2;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd39131;
  localparam logic [RNG_W-1:0] RNG_SEED_RESET = 32'd2463534242;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED = 2'd1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ_WAIT,
    S_SEED,
    S_POP,
    S_POP_WAIT,
    S_NB_RD,
    S_NB_EVAL,
    S_FLIP_RD,
    S_FLIP_WR,
    S_RESP
  } state_t;

  function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] x);
    logic [RNG_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage
`default_nettype wire

[rtl/wolff_cluster_update.sv]
// Wolff cluster update engine over a periodic Ising lattice held in block memory.
// After reset a clearing pass zeroes every lattice site, during which no item is taken. A spin
// write goes through S_RESP to the result register, a spin read through S_READ_WAIT and S_RESP.
// In a cluster update every frontier site costs a queue read (S_POP), a capture step (S_POP_WAIT)
// and, per neighbor, a read (S_NB_RD) and then a test and write back (S_NB_EVAL) on the site
// memory; the flip pass reads each cluster site from the queue and then writes it back flipped.
// Results wait in an output register; one item is worked on at a time.
`default_nettype none
module wolff_cluster_update
  import wcu_pkg::*;
#(
  parameter int LATTICE_SIDE = LATTICE_SIDE_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire logic [KIND_W-1:0]      kind,
  input  wire logic [COORD_IN_W-1:0]  row,
  input  wire logic [COORD_IN_W-1:0]  col,
  input  wire logic                   spin_in,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic                        spin_out,
  output logic [SIZE_W-1:0]           cluster_size,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [RNG_W-1:0]       cfg_data
);

  localparam int CW = $clog2(LATTICE_SIDE);
  localparam int SITES = LATTICE_SIDE * LATTICE_SIDE;
  localparam int AW = $clog2(SITES);
  localparam int QW = 2 * CW;
  localparam logic [AW-1:0] SIDE_A = AW'(LATTICE_SIDE);
  localparam logic [CW-1:0] CMAX = CW'(LATTICE_SIDE - 1);
  localparam logic [AW:0] SITES_C = (AW+1)'(SITES);
  localparam logic [AW:0] LAST_C = (AW+1)'(SITES - 1);

  function automatic logic [AW-1:0] site_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * SIDE_A + AW'(c));
  endfunction

  state_t state, state_next;

  logic [CW-1:0] coord_mod [2**COORD_IN_W];
  for (genvar g = 0; g < 2**COORD_IN_W; g++) begin : g_mod
    assign coord_mod[g] = CW'(g % LATTICE_SIDE);
  end

  logic [CW-1:0] row_m, col_m;
  assign row_m = coord_mod[row];
  assign col_m = coord_mod[col];

  logic [AW:0]            head, tail;
  logic [1:0]             k;
  logic [CW-1:0]          cur_r, cur_c, nb_r, nb_c, nb_r_c, nb_c_c;
  logic                   seed_spin;
  logic [KIND_W-1:0]      kind_r;
  logic [THRESH_W-1:0]    bond_threshold;
  logic [1:0]             mem_rdata;
  logic [QW-1:0]          q_rdata;
  logic [THRESH_W-1:0]    draw;

  logic                   item_accept, cfg_write, out_free, bond, rng_adv;
  logic                   sm_we, sm_re, q_we, q_re;
  logic [AW-1:0]          sm_waddr, sm_raddr, q_waddr, q_raddr;
  logic [1:0]             sm_wdata;
  logic [QW-1:0]          q_wdata;

  logic [1:0]             site_mem [SITES];
  logic [QW-1:0]          frontier_queue [SITES];

  assign item_stall = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign out_free = !result_valid || !result_stall;

  wcu_rng u_rng (
    .clk        (clk),
    .rst        (rst),
    .load       (cfg_write && cfg_index == CFG_SEED),
    .load_value (cfg_data),
    .advance    (rng_adv),
    .draw       (draw)
  );

  always_comb begin
    nb_r_c = cur_r;
    nb_c_c = cur_c;
    case (k)
      2'd0: nb_r_c = (cur_r == CMAX) ? '0 : cur_r + 1'b1;
      2'd1: nb_r_c = (cur_r == '0) ? CMAX : cur_r - 1'b1;
      2'd2: nb_c_c = (cur_c == CMAX) ? '0 : cur_c + 1'b1;
      default: nb_c_c = (cur_c == '0) ? CMAX : cur_c - 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (head == LAST_C) state_next = S_IDLE;
      S_IDLE: begin
        if (item_accept) begin
          case (kind)
            KIND_UPDATE: state_next = S_SEED;
            KIND_READ: state_next = S_READ_WAIT;
            default: state_next = S_RESP;
          endcase
        end
      end
      S_READ_WAIT: state_next = S_RESP;
      S_SEED: state_next = S_POP;
      S_POP: state_next = (head == tail) ? S_FLIP_RD : S_POP_WAIT;
      S_POP_WAIT: state_next = S_NB_RD;
      S_NB_RD: state_next = S_NB_EVAL;
      S_NB_EVAL: state_next = (k == 2'd3) ? S_POP : S_NB_RD;
      S_FLIP_RD: state_next = (head == tail) ? S_RESP : S_FLIP_WR;
      S_FLIP_WR: state_next = S_FLIP_RD;
      S_RESP: if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    sm_we = 1'b0;
    sm_re = 1'b0;
    q_we = 1'b0;
    q_re = 1'b0;
    sm_waddr = '0;
    sm_raddr = '0;
    q_waddr = '0;
    q_raddr = '0;
    sm_wdata = '0;
    q_wdata = '0;
    rng_adv = 1'b0;
    bond = 1'b0;
    case (state)
      S_CLEAR: begin
        sm_we = 1'b1;
        sm_waddr = head[AW-1:0];
      end
      S_IDLE: begin
        if (item_accept) begin
          sm_waddr = site_of(row_m, col_m);
          sm_raddr = site_of(row_m, col_m);
          sm_wdata = {1'b0, spin_in};
          sm_we = (kind == KIND_WRITE);
          sm_re = (kind == KIND_UPDATE) || (kind == KIND_READ);
        end
      end
      S_SEED: begin
        sm_we = 1'b1;
        sm_waddr = site_of(cur_r, cur_c);
        sm_wdata = {1'b1, mem_rdata[0]};
        q_we = 1'b1;
        q_wdata = {cur_r, cur_c};
      end
      S_POP, S_FLIP_RD: begin
        q_re = (head != tail);
        q_raddr = head[AW-1:0];
      end
      S_NB_RD: begin
        sm_re = 1'b1;
        sm_raddr = site_of(nb_r_c, nb_c_c);
      end
      S_NB_EVAL: begin
        rng_adv = (mem_rdata[0] == seed_spin);
        bond = rng_adv && (draw < bond_threshold) && !mem_rdata[1];
        sm_we = bond;
        sm_waddr = site_of(nb_r, nb_c);
        sm_wdata = {1'b1, seed_spin};
        q_we = bond;
        q_waddr = tail[AW-1:0];
        q_wdata = {nb_r, nb_c};
      end
      S_FLIP_WR: begin
        sm_we = 1'b1;
        sm_waddr = site_of(q_rdata[QW-1 -: CW], q_rdata[CW-1:0]);
        sm_wdata = {1'b0, !seed_spin};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sm_we) site_mem[sm_waddr] <= sm_wdata;
    if (sm_re) mem_rdata <= site_mem[sm_raddr];
    if (q_we) frontier_queue[q_waddr] <= q_wdata;
    if (q_re) q_rdata <= frontier_queue[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      head <= '0;
      tail <= '0;
      k <= '0;
      result_valid <= 1'b0;
      bond_threshold <= THRESH_RESET;
    end else begin
      state <= state_next;
      if (cfg_write && cfg_index == CFG_THRESHOLD) bond_threshold <= cfg_data[THRESH_W-1:0];
      case (state)
        S_CLEAR: head <= head + 1'b1;
        S_IDLE: begin
          if (item_accept) begin
            kind_r <= kind;
            cur_r <= row_m;
            cur_c <= col_m;
          end
        end
        S_SEED: begin
          seed_spin <= mem_rdata[0];
          head <= '0;
          tail <= (AW+1)'(1);
        end
        S_POP: head <= (head == tail) ? '0 : head + 1'b1;
        S_POP_WAIT: begin
          cur_r <= q_rdata[QW-1 -: CW];
          cur_c <= q_rdata[CW-1:0];
          k <= '0;
        end
        S_NB_RD: begin
          nb_r <= nb_r_c;
          nb_c <= nb_c_c;
        end
        S_NB_EVAL: begin
          k <= k + 1'b1;
          if (bond) tail <= tail + 1'b1;
        end
        S_FLIP_RD: if (head != tail) head <= head + 1'b1;
        default: ;
      endcase
      if (state == S_RESP && out_free) begin
        result_valid <= 1'b1;
        spin_out <= (kind_r == KIND_READ) ? mem_rdata[0] : 1'b0;
        cluster_size <= (kind_r == KIND_UPDATE) ? SIZE_W'(tail) : '0;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_tail_bound: assert property (@(posedge clk) disable iff (rst) tail <= SITES_C)
    else $error("frontier tail beyond lattice size");

  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP || state == S_FLIP_RD) |-> head <= tail)
    else $error("frontier head passed tail");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> item_stall)
    else $error("item taken during clearing pass");

  a_result_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(spin_out && cluster_size != '0))
    else $error("result carries both spin and cluster size");

endmodule
`default_nettype wire

[rtl/wcu_rng.sv]
// Xorshift32 random generator with load and advance.
`default_nettype none
module wcu_rng
  import wcu_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire logic [RNG_W-1:0]    load_value,
  input  wire logic                advance,
  output logic [THRESH_W-1:0]      draw
);

  logic [RNG_W-1:0] random_state;
  logic [RNG_W-1:0] random_state_next;

  assign random_state_next = xorshift32(random_state);
  assign draw = random_state_next[RNG_W-1 -: THRESH_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      random_state <= RNG_SEED_RESET;
    end else if (load) begin
      random_state <= load_value;
    end else if (advance) begin
      random_state <= random_state_next;
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the Wolff cluster update block: directed table, then random traffic.
module tb_top;
  import wcu_pkg::*;

  localparam int SIDE = 64;
  localparam int SITES = SIDE * SIDE;
  localparam int CYCLE_LIMIT = 30000000;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct {
    bit                  is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [RNG_W-1:0]    data;
    logic [KIND_W-1:0]   k;
    logic [5:0]          r;
    logic [5:0]          c;
    logic                s;
    bit                  typed;
    logic                t_spin;
    logic [SIZE_W-1:0]   t_size;
  } row_t;

  typedef struct {
    logic              spin;
    logic [SIZE_W-1:0] size;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [COORD_IN_W-1:0] row = '0;
  logic [COORD_IN_W-1:0] col = '0;
  logic spin_in = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic spin_out;
  logic [SIZE_W-1:0] cluster_size;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [RNG_W-1:0] cfg_data = '0;

  wolff_cluster_update DUT (.*);

  always #1 clk = ~clk;

  // predictor state
  bit lattice [SITES];
  bit marked [SITES];
  int frontier [SITES];
  logic [THRESH_W-1:0] m_thresh;
  logic [RNG_W-1:0] m_rng;

  outcome_t pending[$];
  int errors = 0;
  int cycles = 0;
  int send_pct = 0;
  int recv_pct = 0;

  function automatic logic [15:0] draw16();
    logic [31:0] x;
    x = m_rng;
    x ^= x << 13;
    x ^= x >> 17;
    x ^= x << 5;
    m_rng = x;
    return x[31:16];
  endfunction

  function automatic int grow_and_flip(int r0, int c0);
    int head, tail, site, r, c, n, nb, sz;
    bit seed_spin;
    int nbs [4];
    head = 0;
    tail = 0;
    sz = 0;
    site = r0 * SIDE + c0;
    seed_spin = lattice[site];
    marked[site] = 1;
    frontier[tail++] = site;
    while (head < tail) begin
      site = frontier[head++];
      r = site / SIDE;
      c = site % SIDE;
      nbs[0] = ((r + 1) % SIDE) * SIDE + c;
      nbs[1] = ((r + SIDE - 1) % SIDE) * SIDE + c;
      nbs[2] = r * SIDE + (c + 1) % SIDE;
      nbs[3] = r * SIDE + (c + SIDE - 1) % SIDE;
      for (n = 0; n < 4; n++) begin
        nb = nbs[n];
        if (lattice[nb] == seed_spin) begin
          if (draw16() < m_thresh && !marked[nb]) begin
            marked[nb] = 1;
            if (tail < SITES) frontier[tail++] = nb;
          end
        end
      end
    end
    for (int s = 0; s < SITES; s++) begin
      if (marked[s]) begin
        lattice[s] ^= 1'b1;
        marked[s] = 0;
        sz++;
      end
    end
    return sz;
  endfunction

  function automatic outcome_t predict(logic [1:0] k, logic [5:0] r, logic [5:0] c, logic s);
    outcome_t o;
    int site;
    o.spin = 1'b0;
    o.size = '0;
    site = int'(r) * SIDE + int'(c);
    case (k)
      KIND_WRITE: lattice[site] = s;
      KIND_UPDATE: o.size = SIZE_W'(grow_and_flip(int'(r), int'(c)));
      KIND_READ: o.spin = lattice[site];
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) result_stall <= ($urandom_range(99) < recv_pct);

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && result_valid && !result_stall) begin
      if (pending.size() == 0) begin
        $error("unexpected transaction: spin_out=%0d cluster_size=%0d", spin_out, cluster_size);
        errors++;
      end else begin
        e = pending.pop_front();
        if (spin_out !== e.spin) begin
          $error("spin_out expected %0d actual %0d", e.spin, spin_out);
          errors++;
        end
        if (cluster_size !== e.size) begin
          $error("cluster_size expected %0d actual %0d", e.size, cluster_size);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [RNG_W-1:0] data);
    item_valid <= 1'b0;
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_THRESHOLD) m_thresh = data[THRESH_W-1:0];
    else if (idx == CFG_SEED) m_rng = data;
  endtask

  task automatic send(logic [1:0] k, logic [5:0] r, logic [5:0] c, logic s,
                      bit typed, logic t_spin, logic [SIZE_W-1:0] t_size);
    outcome_t o;
    if ($urandom_range(99) < send_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_pct) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    row <= r;
    col <= c;
    spin_in <= s;
    do @(posedge clk); while (item_stall);
    o = predict(k, r, c, s);
    if (typed) begin
      o.spin = t_spin;
      o.size = t_size;
    end
    pending.push_back(o);
  endtask

  task automatic random_phase(int count, int pause_at);
    int p;
    logic [1:0] k;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        item_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
      end
      p = $urandom_range(99);
      if (p < 45) k = KIND_WRITE;
      else if (p < 70) k = KIND_READ;
      else if (p < 93) k = KIND_UPDATE;
      else k = KIND_NONE;
      send(k, 6'($urandom), 6'($urandom), 1'($urandom), 0, 0, 0);
    end
  endtask

  row_t table_rows [$];

  initial begin
    row_t t;
    m_thresh = THRESH_RESET;
    m_rng = RNG_SEED_RESET;
    foreach (lattice[i]) begin
      lattice[i] = 0;
      marked[i] = 0;
    end
    table_rows = '{
      '{0, 0, 0, KIND_READ,   0,  0,  0, 1, 0, 0},
      '{0, 0, 0, KIND_WRITE, 63, 63,  1, 1, 0, 0},
      '{0, 0, 0, KIND_READ,  63, 63,  0, 1, 1, 0},
      '{0, 0, 0, KIND_NONE,  63, 63,  1, 1, 0, 0},
      '{0, 0, 0, KIND_READ,  63, 63,  0, 1, 1, 0},
      '{0, 0, 0, KIND_UPDATE, 63, 63, 1, 0, 0, 0},
      '{0, 0, 0, KIND_READ,  63, 0,   0, 0, 0, 0},
      '{1, CFG_THRESHOLD, 0, KIND_NONE, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, KIND_UPDATE, 5,  5,  0, 1, 0, 1},
      '{0, 0, 0, KIND_READ,   5,  5,  0, 1, 1, 0},
      '{0, 0, 0, KIND_WRITE, 0,  63,  1, 1, 0, 0},
      '{0, 0, 0, KIND_WRITE, 63, 0,   1, 1, 0, 0},
      '{0, 0, 0, KIND_UPDATE, 0, 63,  0, 1, 0, 1},
      '{1, CFG_THRESHOLD, 65535, KIND_NONE, 0, 0, 0, 0, 0, 0},
      '{1, CFG_SEED, 0, KIND_NONE, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, KIND_UPDATE, 32, 32, 0, 0, 0, 0},
      '{0, 0, 0, KIND_READ,  32, 32,  0, 0, 0, 0},
      '{1, CFG_SEED, 32'hFFFFFFFF, KIND_NONE, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, KIND_UPDATE, 0,  0,  0, 0, 0, 0},
      '{1, CFG_THRESHOLD, 1, KIND_NONE, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, KIND_UPDATE, 63, 0,  0, 0, 0, 0},
      '{0, 0, 0, KIND_READ,   0,  0,  0, 0, 0, 0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (table_rows[i]) begin
      t = table_rows[i];
      if (t.is_cfg) write_reg(t.idx, t.data);
      else send(t.k, t.r, t.c, t.s, t.typed, t.t_spin, t.t_size);
    end

    write_reg(CFG_THRESHOLD, 20000);
    write_reg(CFG_SEED, 32'h1);
    send_pct = 15;
    recv_pct = 82;
    random_phase(41, -1);

    write_reg(CFG_THRESHOLD, RNG_W'(THRESH_W'($urandom)));
    write_reg(CFG_SEED, $urandom_range(32'hFFFFFFFF, 1));
    send_pct = 82;
    recv_pct = 15;
    random_phase(41, 20);

    write_reg(CFG_THRESHOLD, RNG_W'(THRESH_RESET));
    write_reg(CFG_SEED, RNG_SEED_RESET);
    send_pct = 0;
    recv_pct = 0;
    random_phase(41, -1);

    item_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
